FILE: src/assert_macros.svh
// Assertion helpers for the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NFHT_ASSERT_ON(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NFHT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/nfht_pkg.sv
package nfht_pkg;

    // Request op codes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NULL    = 2'd3;

    // Field widths and table size limit
    localparam int HANDLE_W = 8;
    localparam int OBJ_W    = 16;
    localparam int TBL_MAX  = 256;

    // Free-slot search works on groups of 16 slots
    localparam int GRP   = 16;
    localparam int POS_W = 4;

    typedef logic [OBJ_W-1:0]    t_obj;
    typedef logic [HANDLE_W-1:0] t_handle;

endpackage

FILE: src/next_fit_handle_table.sv
// A request is held, then read (S_READ), then decoded (S_DONE) into the output register.
// A new request is not taken before the previous one finishes, after the slot memory read,
// the two-stage free-slot search (group encode, then group select) and write-back.
// The output register lets the next request enter while a result waits.
// Reset (synchronous, active low) clears the occupancy bitmap, the last granted
// handle and all control state; slot memory contents need no clear.
`include "assert_macros.svh"

module next_fit_handle_table #(
    parameter int SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] handle, [23:8] object_id
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] granted_handle, [23:8] found_object,
                                        // [24] take_reference, [25] drop_reference
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int TBL_N = (SLOTS > nfht_pkg::TBL_MAX) ? nfht_pkg::TBL_MAX :
                           ((SLOTS < 2) ? 2 : SLOTS);
    localparam int IDX_W = $clog2(TBL_N);
    localparam int NGRP  = (TBL_N + nfht_pkg::GRP - 1) / nfht_pkg::GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int SEL_W = GW + nfht_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [1:0]              r_op;
    nfht_pkg::t_handle       r_handle;
    nfht_pkg::t_obj          r_obj;
    logic [TBL_N-1:0]        r_occ;
    logic [IDX_W-1:0]        r_last;
    nfht_pkg::t_obj          r_mem [TBL_N];
    nfht_pkg::t_obj          r_rdata;
    logic                    r_hit;
    logic [NGRP-1:0]         r_hi_any;
    logic [NGRP-1:0]         r_fr_any;
    logic [nfht_pkg::POS_W-1:0] r_hi_pos [NGRP];
    logic [nfht_pkg::POS_W-1:0] r_fr_pos [NGRP];

    logic                    r_o_valid;
    logic [1:0]              r_o_status;
    nfht_pkg::t_handle       r_o_granted;
    nfht_pkg::t_obj          r_o_found;
    logic                    r_o_take;
    logic                    r_o_drop;

    logic [NGRP*nfht_pkg::GRP-1:0] w_free;
    logic [NGRP*nfht_pkg::GRP-1:0] w_hi;
    logic                    w_h_ok;
    logic [IDX_W-1:0]        w_hidx;
    logic                    w_fin;
    logic                    w_accept;
    logic [GW-1:0]           w_hi_grp;
    logic [GW-1:0]           w_fr_grp;
    logic                    w_hi_found;
    logic                    w_full;
    logic [SEL_W-1:0]        w_sel;
    logic [IDX_W-1:0]        w_slot;
    logic                    w_create_ok;
    logic                    w_delete_ok;
    logic [1:0]              w_status;
    nfht_pkg::t_handle       w_granted;
    nfht_pkg::t_obj          w_found;
    logic                    w_take;
    logic                    w_drop;

    // Lowest set bit of a 16-slot group
    function automatic logic [nfht_pkg::POS_W-1:0] first_set(
        input logic [nfht_pkg::GRP-1:0] v
    );
        logic [nfht_pkg::POS_W-1:0] pos;
        pos = '0;
        for (int k = nfht_pkg::GRP - 1; k >= 0; k--) begin
            if (v[k]) begin
                pos = nfht_pkg::POS_W'(k);
            end
        end
        return pos;
    endfunction

    // Handshake
    assign w_fin         = (r_state == S_DONE) && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE) || w_fin;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_fin) n_state = w_accept ? S_READ : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tuser;
            r_handle <= s_axis_tdata[7:0];
            r_obj    <= s_axis_tdata[23:8];
        end
    end

    // Handle range check
    assign w_h_ok = (r_handle != '0) && ({1'b0, r_handle} < 9'(TBL_N));
    assign w_hidx = r_handle[IDX_W-1:0];

    // Free and after-last masks over the padded slot range
    always_comb begin
        for (int i = 0; i < NGRP * nfht_pkg::GRP; i++) begin
            w_free[i] = (i >= 1) && (i < TBL_N) && !r_occ[i];
            w_hi[i]   = w_free[i] && (i > int'(r_last));
        end
    end

    // Read stage: slot memory read, occupancy of the handle, group encode
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rdata <= r_mem[w_hidx];
            r_hit   <= w_h_ok && r_occ[w_hidx];
            for (int g = 0; g < NGRP; g++) begin
                r_hi_any[g] <= |w_hi[g*nfht_pkg::GRP +: nfht_pkg::GRP];
                r_fr_any[g] <= |w_free[g*nfht_pkg::GRP +: nfht_pkg::GRP];
                r_hi_pos[g] <= first_set(w_hi[g*nfht_pkg::GRP +: nfht_pkg::GRP]);
                r_fr_pos[g] <= first_set(w_free[g*nfht_pkg::GRP +: nfht_pkg::GRP]);
            end
        end
    end

    // Group select: first free slot after the last grant, else first free slot
    always_comb begin
        w_hi_grp   = '0;
        w_fr_grp   = '0;
        w_hi_found = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_hi_any[g]) begin
                w_hi_grp   = GW'(g);
                w_hi_found = 1'b1;
            end
            if (r_fr_any[g]) begin
                w_fr_grp = GW'(g);
            end
        end
        w_full = !(|r_fr_any);
        w_sel  = w_hi_found ? {w_hi_grp, r_hi_pos[w_hi_grp]} : {w_fr_grp, r_fr_pos[w_fr_grp]};
    end
    assign w_slot = w_sel[IDX_W-1:0];

    // Result decode
    always_comb begin
        w_status    = nfht_pkg::ST_INVALID;
        w_granted   = '0;
        w_found     = '0;
        w_take      = 1'b0;
        w_drop      = 1'b0;
        w_create_ok = 1'b0;
        w_delete_ok = 1'b0;
        case (r_op) inside
            nfht_pkg::OP_CREATE: begin
                if (r_obj == '0) begin
                    w_status = nfht_pkg::ST_NULL;
                end else if (w_full) begin
                    w_status = nfht_pkg::ST_FULL;
                end else begin
                    w_status    = nfht_pkg::ST_OK;
                    w_granted   = nfht_pkg::HANDLE_W'(w_slot);
                    w_take      = 1'b1;
                    w_create_ok = 1'b1;
                end
            end
            nfht_pkg::OP_LOOKUP, nfht_pkg::OP_DELETE: begin
                if (r_hit) begin
                    w_status    = nfht_pkg::ST_OK;
                    w_found     = r_rdata;
                    w_drop      = (r_op == nfht_pkg::OP_DELETE);
                    w_delete_ok = (r_op == nfht_pkg::OP_DELETE);
                end
            end
            default: begin
                w_status = nfht_pkg::ST_INVALID;
            end
        endcase
    end

    // Write back the bound object
    always_ff @(posedge i_clk) begin
        if (w_fin && w_create_ok) begin
            r_mem[w_slot] <= r_obj;
        end
    end

    // Update occupancy and the last grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_last <= '0;
        end else if (w_fin) begin
            if (w_create_ok) begin
                r_occ[w_slot] <= 1'b1;
                r_last        <= w_slot;
            end
            if (w_delete_ok) begin
                r_occ[w_hidx] <= 1'b0;
            end
        end
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fin) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_o_status  <= w_status;
            r_o_granted <= w_granted;
            r_o_found   <= w_found;
            r_o_take    <= w_take;
            r_o_drop    <= w_drop;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {6'd0, r_o_drop, r_o_take, r_o_found, r_o_granted};

    `NFHT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_o_valid), "reset did not idle the block")
    `NFHT_ASSERT_ON(a_grant_free, i_clk, i_rst_n, (w_fin && w_create_ok) |-> (!r_occ[w_slot] && w_slot != '0), "create granted a busy or reserved slot")
    `NFHT_ASSERT_ON(a_accept_reads, i_clk, i_rst_n, w_accept |=> (r_state == S_READ), "accepted request did not start a read")
    `NFHT_ASSERT_ON(a_last_moves, i_clk, i_rst_n, ($past(i_rst_n) && r_last != $past(r_last)) |-> $past(w_fin && w_create_ok), "last grant moved without a create")

endmodule

FILE: test/tb_next_fit_handle_table.sv
module tb_next_fit_handle_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS       = 256;
    localparam int LIMIT_CYCLES = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_PER_PASS = 30;
    // Op code three is unused by the block: it must answer as a no-op
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        nfht_pkg::t_handle granted;
        nfht_pkg::t_obj    found;
        logic              take;
        logic              drop;
    } t_handle_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data  = '0;      // [7:0] handle, [23:8] object_id
    logic [1:0]  s_user  = '0;      // [1:0] op
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;            // [7:0] granted, [23:8] found, [24] take, [25] drop
    logic [1:0]  m_user;            // [1:0] status

    // Shadow copy of the handle table
    nfht_pkg::t_obj    slot_obj [NSLOTS];
    nfht_pkg::t_handle last_grant;

    t_handle_result pending_results [$];
    t_handle_result got_result;
    t_handle_result want_result;
    int errors = 0;
    int cycles = 0;
    bit calm   = 1'b0;

    next_fit_handle_table #(
        .SLOTS(NSLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_user),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tuser (m_user)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the answer it must give
    function automatic t_handle_result predict_handle_op(logic [1:0] op,
                                                         nfht_pkg::t_handle h,
                                                         nfht_pkg::t_obj obj);
        t_handle_result r;
        int c;
        int last;
        r = '0;
        r.status = nfht_pkg::ST_INVALID;
        case (op)
            nfht_pkg::OP_CREATE: begin
                if (obj == '0) begin
                    r.status = nfht_pkg::ST_NULL;
                end else begin
                    r.status = nfht_pkg::ST_FULL;
                    last = int'(last_grant);
                    // Next fit: start after the last grant, wrap past the top to slot 1
                    for (int i = 1; i < NSLOTS; i++) begin
                        c = 1 + ((last + i - 1) % (NSLOTS - 1));
                        if (slot_obj[c] == '0) begin
                            slot_obj[c] = obj;
                            last_grant  = nfht_pkg::t_handle'(c);
                            r.status    = nfht_pkg::ST_OK;
                            r.granted   = nfht_pkg::t_handle'(c);
                            r.take      = 1'b1;
                            break;
                        end
                    end
                end
            end
            nfht_pkg::OP_LOOKUP, nfht_pkg::OP_DELETE: begin
                if (h != '0 && slot_obj[h] != '0) begin
                    r.status = nfht_pkg::ST_OK;
                    r.found  = slot_obj[h];
                    if (op == nfht_pkg::OP_DELETE) begin
                        slot_obj[h] = '0;
                        r.drop      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request, with a random gap in front, and record its answer once taken
    task automatic send_request(input logic [1:0] op, input nfht_pkg::t_handle h,
                                input nfht_pkg::t_obj obj);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 7) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {obj, h};
        do @(posedge i_clk); while (!s_ready);
        pending_results.push_back(predict_handle_op(op, h, obj));
    endtask

    // Hold requests back until every answer is in
    task automatic hold_off;
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        // Bad handle, empty slot, null object
        send_request(nfht_pkg::OP_LOOKUP, 8'h00, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'h00, 16'hFFFF);
        send_request(nfht_pkg::OP_LOOKUP, 8'hFF, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'hFF, 16'h0000);
        send_request(nfht_pkg::OP_CREATE, 8'h00, 16'h0000);
        // First grants come from slot 1 upward
        send_request(nfht_pkg::OP_CREATE, 8'hFF, 16'hFFFF);
        send_request(nfht_pkg::OP_CREATE, 8'h00, 16'h0001);
        send_request(nfht_pkg::OP_LOOKUP, 8'h01, 16'h0000);
        send_request(nfht_pkg::OP_LOOKUP, 8'h02, 16'hFFFF);
        send_request(nfht_pkg::OP_DELETE, 8'h02, 16'h0000);
        send_request(nfht_pkg::OP_LOOKUP, 8'h02, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'h02, 16'h0000);
        // Freed slot 2 is the last grant itself, so next fit starts past it and skips it
        send_request(nfht_pkg::OP_CREATE, 8'h02, 16'h8000);
        send_request(nfht_pkg::OP_LOOKUP, 8'h03, 16'h0000);
        // Unused op code answers as a no-op
        send_request(OP_NONE, 8'hFF, 16'hFFFF);
        send_request(OP_NONE, 8'h00, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'h01, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'h03, 16'h0000);
        send_request(nfht_pkg::OP_LOOKUP, 8'h01, 16'h0000);
    endtask

    task automatic test_full_table;
        int free_slots;
        free_slots = 0;
        for (int i = 1; i < NSLOTS; i++) begin
            if (slot_obj[i] == '0) free_slots++;
        end
        // Fill every slot, the wrap back to slot 1 included
        for (int i = 0; i < free_slots; i++) begin
            send_request(nfht_pkg::OP_CREATE, nfht_pkg::t_handle'($urandom_range(0, 255)),
                         nfht_pkg::t_obj'($urandom_range(1, 65535)));
        end
        send_request(nfht_pkg::OP_CREATE, 8'h00, 16'hFFFF);
        send_request(nfht_pkg::OP_CREATE, 8'hFF, 16'h0001);
        send_request(nfht_pkg::OP_LOOKUP, 8'hFF, 16'h0000);
        send_request(nfht_pkg::OP_DELETE, 8'hFF, 16'h0000);
        send_request(nfht_pkg::OP_LOOKUP, 8'hFF, 16'h0000);
        // The only free slot is the top one
        send_request(nfht_pkg::OP_CREATE, 8'h00, 16'h5A5A);
        send_request(nfht_pkg::OP_CREATE, 8'h00, 16'hA5A5);
        hold_off();
    endtask

    task automatic test_random;
        int wc;
        int wl;
        int r;
        logic [1:0] op;
        nfht_pkg::t_handle h;
        nfht_pkg::t_obj obj;
        for (int p = 0; p < 4; p++) begin
            // Delete-heavy pass, create-heavy pass, then mixes
            case (p)
                0:       begin wc = 15; wl = 25; end
                1:       begin wc = 60; wl = 20; end
                2:       begin wc = 35; wl = 30; end
                default: begin wc = 30; wl = 40; end
            endcase
            calm = (p == 1);
            for (int n = 0; n < RAND_PER_PASS; n++) begin
                r = $urandom_range(99);
                if (r < wc)           op = nfht_pkg::OP_CREATE;
                else if (r < wc + wl) op = nfht_pkg::OP_LOOKUP;
                else if (r < 97)      op = nfht_pkg::OP_DELETE;
                else                  op = OP_NONE;
                case ($urandom_range(9))
                    0:       h = $urandom_range(1) ? 8'hFF : 8'h00;
                    1:       h = nfht_pkg::t_handle'($urandom_range(0, 255));
                    default: h = nfht_pkg::t_handle'($urandom_range(1, 255));
                endcase
                obj = ($urandom_range(99) < 3) ? '0 :
                      nfht_pkg::t_obj'($urandom_range(1, 65535));
                send_request(op, h, obj);
            end
        end
        calm = 1'b0;
    endtask

    // Drive the result side ready with random stalls
    always @(negedge i_clk) begin
        m_ready <= calm || ($urandom_range(99) >= 7);
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each answer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            got_result = {m_user, m_data[7:0], m_data[23:8], m_data[24], m_data[25]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_result);
                errors++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("status", 16'(want_result.status), 16'(got_result.status));
                check_field("granted_handle", 16'(want_result.granted),
                            16'(got_result.granted));
                check_field("found_object", want_result.found, got_result.found);
                check_field("take_reference", 16'(want_result.take), 16'(got_result.take));
                check_field("drop_reference", 16'(want_result.drop), 16'(got_result.drop));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("next_fit_handle_table test failed");
            $finish;
        end
    end

    initial begin
        foreach (slot_obj[i]) slot_obj[i] = '0;
        last_grant = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random();

        // Let the last answers out, then watch for strays
        hold_off();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("next_fit_handle_table test passed");
        end else begin
            $display("next_fit_handle_table test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/nfht_pkg.sv
src/next_fit_handle_table.sv
test/tb_next_fit_handle_table.sv
